// File: src/assert_macros.svh
// assertion macros shared by the pulse scheduler modules
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define TPS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property on every rising clock edge, reset included
`define TPS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/tps_pkg.sv
// types, codes and sizes of the timed pulse scheduler
// used by tps_ctrl, tps_datapath and timed_pulse_scheduler; no dependencies
package tps_pkg;

   // queue depth and ticks per microsecond must be powers of two
   localparam int unsigned QUEUE_DEPTH  = 8;
   localparam int unsigned TICKS_PER_US = 16;

   localparam int unsigned PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned TICK_SHIFT = $clog2(TICKS_PER_US);

   localparam int unsigned US_W   = 60;
   localparam int unsigned TICK_W = 64;
   localparam int unsigned SEQ_W  = 32;
   localparam int unsigned WID_W  = 32;
   localparam int unsigned REG_W  = 32;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [TICK_W-1:0] TICK_MASK = TICK_W'(TICKS_PER_US - 1);

   localparam logic [REG_W-1:0] SESSION_RESET   = 32'd0;
   localparam logic [REG_W-1:0] MIN_LEAD_RESET  = 32'd50000;
   localparam logic [REG_W-1:0] MAX_WIDTH_RESET = 32'd2000000;

   // request commands
   localparam logic [1:0] CMD_SCHEDULE  = 2'd0;
   localparam logic [1:0] CMD_TICK      = 2'd1;
   localparam logic [1:0] CMD_FORCE_LOW = 2'd2;
   localparam logic [1:0] CMD_EDGE      = 2'd3;

   // record kinds
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_PULSE  = 2'd1;
   localparam logic [1:0] KIND_INPUT  = 2'd2;

   // schedule status codes
   localparam logic [1:0] ST_ACCEPTED   = 2'd0;
   localparam logic [1:0] ST_INVALID    = 2'd1;
   localparam logic [1:0] ST_QUEUE_FULL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SESSION   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEAD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WIDTH = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic [SEQ_W-1:0]  pulse_sequence;
      logic [TICK_W-1:0] due_tick;
      logic [WID_W-1:0]  width_req_us;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        status;
      logic [SEQ_W-1:0]  rec_sequence;
      logic [TICK_W-1:0] plan_tick;
      logic [TICK_W-1:0] stamp_tick;
      logic [WID_W-1:0]  rec_width_us;
      logic [REG_W-1:0]  rec_session;
      logic              pin_level;
   } rsp_type;

   // one queued pulse; end time kept so a load needs no add
   typedef struct packed {
      logic [SEQ_W-1:0] sequence_no;
      logic [US_W-1:0]  due_us;
      logic [WID_W-1:0] span_us;
      logic [US_W-1:0]  end_us;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic       latch_req;
      logic       calc_sum;
      logic       calc_diff;
      logic       calc_cmp;
      logic       arm;
      logic       push;
      logic       tick_inc;
      logic       fall;
      logic       load;
      logic       disarm;
      logic       rise;
      logic       force_low;
      logic       edge_inc;
      logic       emit;
      logic [1:0] kind;
      logic [1:0] status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sched_invalid;
      logic sched_full;
      logic armed;
      logic fall_due;
      logic fifo_empty;
      logic rise_due;
      logic rsp_free;
   } stat_type;

endpackage

// File: src/tps_ctrl.sv
// controller state machine of the pulse scheduler
// depends on tps_pkg and assert_macros.svh; drives tps_datapath through cmd_type
`include "assert_macros.svh"

module tps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_command,
   output logic              req_ready,
   input  tps_pkg::stat_type stat,
   output tps_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SUM       = 4'd1;
   localparam logic [3:0] S_DIFF      = 4'd2;
   localparam logic [3:0] S_CMP       = 4'd3;
   localparam logic [3:0] S_APPLY     = 4'd4;
   localparam logic [3:0] S_TICK_INC  = 4'd5;
   localparam logic [3:0] S_TICK_FALL = 4'd6;
   localparam logic [3:0] S_TICK_RISE = 4'd7;
   localparam logic [3:0] S_FORCE     = 4'd8;
   localparam logic [3:0] S_EDGE      = 4'd9;
   localparam logic [3:0] S_EMIT      = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [1:0] kind_ff, kind_in;
   logic [1:0] status_ff, status_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      kind_in   = kind_ff;
      status_in = status_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               unique case (req_command)
                  tps_pkg::CMD_SCHEDULE:  state_in = S_SUM;
                  tps_pkg::CMD_TICK:      state_in = S_TICK_INC;
                  tps_pkg::CMD_FORCE_LOW: state_in = S_FORCE;
                  tps_pkg::CMD_EDGE:      state_in = S_EDGE;
                  default:                state_in = S_IDLE;
               endcase
            end
         end
         S_SUM: begin
            cmd.calc_sum = 1'b1;
            state_in     = S_DIFF;
         end
         S_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = S_CMP;
         end
         S_CMP: begin
            cmd.calc_cmp = 1'b1;
            state_in     = S_APPLY;
         end
         S_APPLY: begin
            kind_in = tps_pkg::KIND_STATUS;
            priority if (stat.sched_invalid) begin
               status_in = tps_pkg::ST_INVALID;
            end else if (stat.armed && stat.sched_full) begin
               status_in = tps_pkg::ST_QUEUE_FULL;
            end else if (stat.armed) begin
               status_in = tps_pkg::ST_ACCEPTED;
               cmd.push  = 1'b1;
            end else begin
               status_in = tps_pkg::ST_ACCEPTED;
               cmd.arm   = 1'b1;
            end
            state_in = S_EMIT;
         end
         S_TICK_INC: begin
            cmd.tick_inc = 1'b1;
            state_in     = S_TICK_FALL;
         end
         S_TICK_FALL: begin
            // the fall is handled before a possible rise in the same tick
            if (stat.fall_due) begin
               cmd.fall   = 1'b1;
               cmd.load   = !stat.fifo_empty;
               cmd.disarm = stat.fifo_empty;
            end
            state_in = S_TICK_RISE;
         end
         S_TICK_RISE: begin
            if (stat.rise_due) begin
               cmd.rise  = 1'b1;
               kind_in   = tps_pkg::KIND_PULSE;
               status_in = tps_pkg::ST_ACCEPTED;
               state_in  = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FORCE: begin
            cmd.force_low = 1'b1;
            state_in      = S_IDLE;
         end
         S_EDGE: begin
            cmd.edge_inc = 1'b1;
            kind_in      = tps_pkg::KIND_INPUT;
            status_in    = tps_pkg::ST_ACCEPTED;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      cmd.kind   = kind_ff;
      cmd.status = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         kind_ff   <= tps_pkg::KIND_STATUS;
         status_ff <= tps_pkg::ST_ACCEPTED;
      end else begin
         state_ff  <= state_in;
         kind_ff   <= kind_in;
         status_ff <= status_in;
      end
   end

   `TPS_ASSERT(a_one_item_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready, "item accepted while another is at work")
   `TPS_ASSERT(a_status_only_on_schedule, clock, reset, cmd.emit && (cmd.kind != tps_pkg::KIND_STATUS) |-> (cmd.status == tps_pkg::ST_ACCEPTED), "nonzero status on a record that is not a schedule status")

endmodule

// File: src/tps_datapath.sv
// datapath of the pulse scheduler: registers, counter, pulse queue, compares, result register
// depends on tps_pkg and assert_macros.svh; controlled by tps_ctrl
`include "assert_macros.svh"

module tps_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  tps_pkg::req_type                 req_data,
   input  tps_pkg::cmd_type                 cmd,
   output tps_pkg::stat_type                stat,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tps_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   input  logic [tps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tps_pkg::REG_W-1:0]        csr_data
);

   localparam int unsigned US_W  = tps_pkg::US_W;
   localparam int unsigned PTR_W = tps_pkg::PTR_W;
   localparam int unsigned CNT_W = tps_pkg::CNT_W;

   // configuration
   logic [tps_pkg::REG_W-1:0] session_ff, min_lead_ff, max_width_ff;

   // latched request and schedule checks
   tps_pkg::req_type          req_ff;
   logic [tps_pkg::TICK_W-1:0] tgt_wide;
   logic [US_W-1:0]           req_target;
   logic [US_W:0]             sum_ff, diff_ff;
   logic                      param_bad_ff, lead_bad_ff, le_last_ff;

   // pulse state
   logic [US_W-1:0]           now_ff, now_in;
   logic                      armed_ff, rise_done_ff, level_ff;
   logic [tps_pkg::SEQ_W-1:0] cur_seq_ff;
   logic [US_W-1:0]           cur_target_ff, cur_end_ff, last_target_ff;
   logic [tps_pkg::WID_W-1:0] cur_width_ff;
   logic [PTR_W-1:0]          head_ff, tail;
   logic [CNT_W-1:0]          count_ff;
   logic [tps_pkg::SEQ_W-1:0] edge_ff;

   // pulse queue
   tps_pkg::entry_type        mem [tps_pkg::QUEUE_DEPTH];
   tps_pkg::entry_type        rd_ff, wr_entry;

   // result register
   logic                      rsp_valid_ff;
   tps_pkg::rsp_type          rsp_data_ff, rec_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         session_ff   <= tps_pkg::SESSION_RESET;
         min_lead_ff  <= tps_pkg::MIN_LEAD_RESET;
         max_width_ff <= tps_pkg::MAX_WIDTH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            tps_pkg::CSR_SESSION:   session_ff   <= csr_data;
            tps_pkg::CSR_MIN_LEAD:  min_lead_ff  <= csr_data;
            tps_pkg::CSR_MAX_WIDTH: max_width_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign tgt_wide   = req_ff.due_tick >> tps_pkg::TICK_SHIFT;
   assign req_target = tgt_wide[US_W-1:0];

   // schedule checks, one wide operation per step
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
      if (cmd.calc_sum) begin
         sum_ff       <= {1'b0, req_target} + (US_W + 1)'(req_ff.width_req_us);
         param_bad_ff <= ((req_ff.due_tick & tps_pkg::TICK_MASK) != '0)
                         || (tgt_wide[tps_pkg::TICK_W-1:US_W] != '0)
                         || (req_ff.width_req_us == '0)
                         || (req_ff.width_req_us > max_width_ff);
      end
      if (cmd.calc_diff) begin
         diff_ff <= {1'b0, req_target} - {1'b0, now_ff};
      end
      if (cmd.calc_cmp) begin
         // borrow means target before now
         lead_bad_ff <= diff_ff[US_W] || (diff_ff[US_W-1:0] == '0)
                        || (diff_ff[US_W-1:0] < US_W'(min_lead_ff));
         le_last_ff  <= (req_target <= last_target_ff);
      end
   end

   assign now_in = now_ff + US_W'(1);
   assign tail   = head_ff + PTR_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff         <= '0;
         armed_ff       <= 1'b0;
         rise_done_ff   <= 1'b0;
         level_ff       <= 1'b0;
         cur_seq_ff     <= '0;
         cur_target_ff  <= '0;
         cur_width_ff   <= '0;
         cur_end_ff     <= '0;
         last_target_ff <= '0;
         head_ff        <= '0;
         count_ff       <= '0;
         edge_ff        <= '0;
      end else begin
         if (cmd.tick_inc) begin
            now_ff <= now_in;
         end
         if (cmd.arm) begin
            armed_ff       <= 1'b1;
            rise_done_ff   <= 1'b0;
            cur_seq_ff     <= req_ff.pulse_sequence;
            cur_target_ff  <= req_target;
            cur_width_ff   <= req_ff.width_req_us;
            cur_end_ff     <= sum_ff[US_W-1:0];
            last_target_ff <= req_target;
         end
         if (cmd.push) begin
            count_ff       <= count_ff + CNT_W'(1);
            last_target_ff <= req_target;
         end
         if (cmd.fall) begin
            level_ff     <= 1'b0;
            rise_done_ff <= 1'b0;
            if (cmd.load) begin
               cur_seq_ff    <= rd_ff.sequence_no;
               cur_target_ff <= rd_ff.due_us;
               cur_width_ff  <= rd_ff.span_us;
               cur_end_ff    <= rd_ff.end_us;
               head_ff       <= head_ff + PTR_W'(1);
               count_ff      <= count_ff - CNT_W'(1);
            end
            if (cmd.disarm) begin
               armed_ff       <= 1'b0;
               last_target_ff <= '0;
            end
         end
         if (cmd.rise) begin
            level_ff     <= 1'b1;
            rise_done_ff <= 1'b1;
         end
         if (cmd.force_low) begin
            count_ff       <= '0;
            head_ff        <= '0;
            armed_ff       <= 1'b0;
            rise_done_ff   <= 1'b0;
            level_ff       <= 1'b0;
            last_target_ff <= '0;
         end
         if (cmd.edge_inc) begin
            edge_ff <= edge_ff + tps_pkg::SEQ_W'(1);
         end
      end
   end

   assign wr_entry.sequence_no = req_ff.pulse_sequence;
   assign wr_entry.due_us      = req_target;
   assign wr_entry.span_us     = req_ff.width_req_us;
   assign wr_entry.end_us      = sum_ff[US_W-1:0];

   // head entry is read every cycle so it is ready when a tick reaches the fall step
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail] <= wr_entry;
      end
      rd_ff <= mem[head_ff];
   end

   assign stat.sched_invalid = param_bad_ff || sum_ff[US_W] || lead_bad_ff;
   assign stat.sched_full    = le_last_ff || (count_ff == CNT_W'(tps_pkg::QUEUE_DEPTH));
   assign stat.armed         = armed_ff;
   assign stat.fall_due      = armed_ff && rise_done_ff && (now_ff >= cur_end_ff);
   assign stat.fifo_empty    = (count_ff == '0);
   assign stat.rise_due      = armed_ff && !rise_done_ff && (now_ff >= cur_target_ff);
   assign stat.rsp_free      = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rec_in                 = '0;
      rec_in.kind            = cmd.kind;
      rec_in.status          = cmd.status;
      rec_in.stamp_tick      = tps_pkg::TICK_W'(now_ff) << tps_pkg::TICK_SHIFT;
      rec_in.rec_session     = session_ff;
      rec_in.pin_level       = level_ff;
      unique case (cmd.kind)
         tps_pkg::KIND_PULSE: begin
            rec_in.rec_sequence = cur_seq_ff;
            rec_in.plan_tick    = tps_pkg::TICK_W'(cur_target_ff) << tps_pkg::TICK_SHIFT;
            rec_in.rec_width_us = cur_width_ff;
         end
         tps_pkg::KIND_INPUT: rec_in.rec_sequence = edge_ff;
         default:             rec_in.rec_sequence = req_ff.pulse_sequence;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_data_ff <= rec_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TPS_ASSERT(a_queue_needs_armed, clock, reset, (count_ff != '0) |-> armed_ff, "queued pulses while disarmed")
   `TPS_ASSERT(a_pin_high_in_pulse, clock, reset, level_ff |-> (armed_ff && rise_done_ff), "pin high outside a risen pulse")
   `TPS_ASSERT(a_no_result_overwrite, clock, reset, !(cmd.emit && rsp_valid_ff && !rsp_ready), "result overwritten before it was taken")
   `TPS_ASSERT(a_pulse_record_pin_high, clock, reset, cmd.emit && (cmd.kind == tps_pkg::KIND_PULSE) |=> rsp_data_ff.pin_level, "pulse record with pin low")

endmodule

// File: src/timed_pulse_scheduler.sv
// Timed pulse scheduler: one item at a time through a controller that sequences a
// datapath. A schedule item goes through one wide add or compare per step (end-time
// sum, lead difference, lead and order compares), then the update and the status
// item; a tick goes through the counter step, the fall check with the queue head
// read from the registered memory port and the rise check, with a record when the
// pulse rises; a force low and an input edge each have their own step, the edge
// followed by its record. A result sits in an output register, so the next item is
// taken while it waits; a new result waits only while that register is still full.
// No clearing pass follows reset. Configuration writes are taken in any cycle.
// Depends on tps_pkg, tps_ctrl and tps_datapath.

module timed_pulse_scheduler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tps_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tps_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tps_pkg::REG_W-1:0]     csr_data
);

   tps_pkg::cmd_type  cmd;
   tps_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   tps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_ready   (req_ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   tps_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
